@@ hdl/bmpse_pkg.sv @@
`default_nettype none
package bmpse_pkg;

	localparam int unsigned COMP_W   = 16;
	localparam int unsigned DIM_W    = 13;
	localparam int unsigned CNT_W    = 12;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned HDR_LEN  = 54;
	localparam int unsigned LANES    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic signed [COMP_W-1:0] ONE_Q12 = 16'sd4096;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic [DIM_W-1:0] dim_t;

	// header byte at position idx of the 54-byte file header
	function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input dim_t w,
			input dim_t h, input logic [31:0] img);
		logic [5:0]  off;
		logic [31:0] v;
		logic [7:0]  b;
		off = idx - 6'd2;
		unique case (off[5:2])
			4'd0:    v = img + 32'd54;
			4'd2:    v = 32'd54;
			4'd3:    v = 32'd40;
			4'd4:    v = {19'd0, w};
			4'd5:    v = {19'd0, h};
			4'd6:    v = 32'h0018_0001; // planes then bits per pixel
			4'd8:    v = img;
			default: v = 32'd0;
		endcase
		unique case (off[1:0])
			2'd0:    b = v[7:0];
			2'd1:    b = v[15:8];
			2'd2:    b = v[23:16];
			default: b = v[31:24];
		endcase
		if (idx == 6'd0) begin
			b = 8'h42;
		end else if (idx == 6'd1) begin
			b = 8'h4D;
		end
		return b;
	endfunction

endpackage
`default_nettype wire

@@ hdl/bmpse_pix_if.sv @@
`default_nettype none
interface bmpse_pix_if;
	logic valid;
	logic ready;
	logic signed [15:0] red;
	logic signed [15:0] green;
	logic signed [15:0] blue;
	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

@@ hdl/bmpse_byte_if.sv @@
`default_nettype none
interface bmpse_byte_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_item;
	logic end_of_frame;
	modport source (output valid, output out_byte, output last_of_item, output end_of_frame,
		input ready);
	modport sink (input valid, input out_byte, input last_of_item, input end_of_frame,
		output ready);
endinterface
`default_nettype wire

@@ hdl/bmpse_cfg_if.sv @@
`default_nettype none
interface bmpse_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [12:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/bmp24_stream_encoder_top.sv @@
// 24-bit BMP stream writer.
// pixels: one RGB pixel per item, signed Q4.12 components, file order (bottom row first).
// bytes: one file byte per item; last_of_item marks the final byte caused by a pixel,
//   end_of_frame the final byte of the file.
// cfg: register writes (0 width, 1 height), always ready; write only while idle.
// A frame's first pixel is preceded by the 54-byte header; rows get zero padding to
// a 4-byte boundary.
// One pixel is processed at a time. When the largest component exceeds 1.0 the three
// lanes divide by it, one quotient bit per cycle; the header is sent
// meanwhile. Otherwise the lane bytes are ready the cycle after accept.
// Between accepts a frame's first pixel sends the header, its three lane bytes and any
// row padding, any other pixel its lane bytes and padding, after the lanes when they
// divide; this is set by the eight-step lane divider and the one-byte-per-cycle output.
// The output register holds its byte while the receiver stalls, which delays the next
// accept; the pixel side accepts the next item as soon as the last byte sits in that
// register.
// Reset clears the counters (next pixel starts a frame) and sets both dimensions to 1.
`default_nettype none
module bmp24_stream_encoder_top #(
	parameter int unsigned MAX_DIM = 4096
) (
	input wire logic    clk,
	input wire logic    arst_n,
	bmpse_pix_if.sink   pixels,
	bmpse_byte_if.source bytes,
	bmpse_cfg_if.sink   cfg
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HDR  = 2'd1;
	localparam logic [1:0] ST_PIX  = 2'd2;
	localparam logic [1:0] ST_PAD  = 2'd3;
	localparam logic [16:0] MAXD   = 17'(MAX_DIM);

	bmpse_pkg::dim_t width_q, height_q, w_eff, h_eff, w_q, h_q;
	logic [bmpse_pkg::CNT_W-1:0] col_q, row_q;
	logic [1:0]  state_q;
	logic [5:0]  idx_q;
	logic [1:0]  pad_q;
	logic [15:0] row_bytes_q;
	logic [31:0] img_s1;
	logic        eor_q, eof_q;
	logic        ovalid_q, olast_q, oeof_q;
	logic [7:0]  obyte_q;

	logic        in_fire, advance, emit, col_end, row_end, first;
	logic [7:0]  nbyte;
	logic        nlast;
	bmpse_pkg::comp_t maxv;
	bmpse_pkg::comp_t comps [bmpse_pkg::LANES];
	logic [bmpse_pkg::LANES-1:0] lane_done;
	logic [7:0]  lane_res [bmpse_pkg::LANES];

	function automatic bmpse_pkg::dim_t eff(input bmpse_pkg::dim_t v);
		bmpse_pkg::dim_t r;
		r = v;
		if (v == '0) begin
			r = 13'd1;
		end else if ({4'd0, v} > MAXD) begin
			r = MAXD[12:0];
		end
		return r;
	endfunction

	always_comb begin
		w_eff    = eff(width_q);
		h_eff    = eff(height_q);
		in_fire  = pixels.valid && pixels.ready;
		col_end  = ({1'b0, col_q} + 13'd1) >= w_eff;
		row_end  = ({1'b0, row_q} + 13'd1) >= h_eff;
		first    = (col_q == '0) && (row_q == '0);
		maxv     = pixels.red;
		if (pixels.green > maxv) maxv = pixels.green;
		if (pixels.blue > maxv) maxv = pixels.blue;
		comps[0] = pixels.blue;
		comps[1] = pixels.green;
		comps[2] = pixels.red;
	end

	for (genvar i = 0; i < bmpse_pkg::LANES; i++) begin : g_lane
		bmpse_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (in_fire),
			.comp   (comps[i]),
			.maxv   (maxv),
			.done   (lane_done[i]),
			.result (lane_res[i])
		);
	end

	assign cfg.ready    = 1'b1;
	assign pixels.ready = state_q == ST_IDLE;
	assign advance      = !ovalid_q || bytes.ready;

	// merge: pick header, lane or pad byte for the output register
	always_comb begin
		emit  = 1'b0;
		nbyte = 8'd0;
		nlast = 1'b0;
		unique case (state_q)
			ST_HDR: begin
				emit  = advance;
				nbyte = bmpse_pkg::hdr_byte(idx_q, w_q, h_q, img_s1);
			end
			ST_PIX: begin
				emit  = advance && (&lane_done);
				nbyte = (idx_q[1:0] == 2'd0) ? lane_res[0] :
					((idx_q[1:0] == 2'd1) ? lane_res[1] : lane_res[2]);
				nlast = (idx_q[1:0] == 2'd2) && (!eor_q || pad_q == 2'd0);
			end
			ST_PAD: begin
				emit  = advance;
				nlast = idx_q[1:0] == (pad_q - 2'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1;
			height_q <= 13'd1;
		end else if (cfg.valid) begin
			if (cfg.index == bmpse_pkg::REG_WIDTH) begin
				width_q <= cfg.data;
			end else if (cfg.index == bmpse_pkg::REG_HEIGHT) begin
				height_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				idx_q   <= '0;
				state_q <= first ? ST_HDR : ST_PIX;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 12'd1;
				end
			end else if (emit) begin
				unique case (state_q)
					ST_HDR: begin
						if (idx_q == 6'(bmpse_pkg::HDR_LEN - 1)) begin
							state_q <= ST_PIX;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
					ST_PIX: begin
						if (idx_q[1:0] == 2'd2) begin
							state_q <= nlast ? ST_IDLE : ST_PAD;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
					ST_PAD: begin
						if (nlast) begin
							state_q <= ST_IDLE;
						end
						idx_q <= idx_q + 6'd1;
					end
					default: ;
				endcase
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (bytes.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			w_q         <= w_eff;
			h_q         <= h_eff;
			pad_q       <= w_eff[1:0];
			row_bytes_q <= 16'({w_eff, 1'b0} + {1'b0, w_eff}) + {14'd0, w_eff[1:0]};
			eor_q       <= col_end;
			eof_q       <= col_end && row_end;
		end
		img_s1 <= 32'(row_bytes_q * h_q);
		if (emit) begin
			obyte_q <= nbyte;
			olast_q <= nlast;
			oeof_q  <= nlast && eof_q;
		end
	end

	assign bytes.valid        = ovalid_q;
	assign bytes.out_byte     = obyte_q;
	assign bytes.last_of_item = olast_q;
	assign bytes.end_of_frame = oeof_q;

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		bytes.valid && bytes.end_of_frame |-> bytes.last_of_item)
		else $error("end of frame without last byte of item");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("sequencer idle after pixel accept");
	a_pix_lanes_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit && state_q == ST_PIX |-> (&lane_done))
		else $error("pixel byte sent before lanes finished");
endmodule
`default_nettype wire

@@ hdl/bmpse_lane.sv @@
`default_nettype none
module bmpse_lane (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire bmpse_pkg::comp_t comp,
	input  wire bmpse_pkg::comp_t maxv,
	output logic                done,
	output logic [7:0]          result
);
	logic [15:0] rem_q;
	logic [7:0]  nlo_q;
	logic [7:0]  quo_q;
	logic [14:0] div_q;
	logic [3:0]  cnt_q;
	logic        busy_q;

	logic [22:0] num;
	logic [12:0] clamped;
	logic [20:0] prod;
	logic [16:0] trial;
	logic        scale;

	always_comb begin
		// 255 * c as (c << 8) - c
		num     = {comp[14:0], 8'd0} - {8'd0, comp[14:0]};
		scale   = maxv > bmpse_pkg::ONE_Q12;
		clamped = comp[15] ? 13'd0 : ((comp > bmpse_pkg::ONE_Q12) ? 13'd4096 : comp[12:0]);
		prod    = {clamped, 8'd0} - {8'd0, clamped};
		trial   = {rem_q, nlo_q[7]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= scale && !comp[15] && (comp != '0);
			cnt_q  <= 4'd8;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 4'd1;
			busy_q <= cnt_q != 4'd1;
		end
	end

	// restoring divide, one quotient bit per cycle; quotient fits 8 bits since c <= max
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[22:8]};
			nlo_q <= num[7:0];
			div_q <= maxv[14:0];
			quo_q <= scale ? 8'd0 : prod[19:12] | {8{prod[20]}};
		end else if (busy_q) begin
			nlo_q <= {nlo_q[6:0], 1'b0};
			if (trial >= {2'b0, div_q}) begin
				rem_q <= 16'(trial - {2'b0, div_q});
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign done   = !busy_q;
	assign result = quo_q;
endmodule
`default_nettype wire
